// ===== design/cag_pkg.sv =====
// Shared types and constants for the CIGAR alignment geometry core.
// No dependencies.
`default_nettype none

package cag_pkg;

  localparam int OP_LEN_BITS_DEF = 28;
  localparam int ACC_BITS_DEF    = 40;

  localparam int CODE_BITS = 4;
  localparam int TAG_BITS  = 32;
  localparam int OUT_BITS  = 40;
  localparam int M_TDATA_W = 5 * OUT_BITS;

  typedef enum logic [CODE_BITS-1:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } op_code_t;

endpackage

`default_nettype wire

// ===== design/cigar_alignment_geometry_core.sv =====
// CIGAR alignment geometry core: accumulates CIGAR ops and emits PAF style
// query length, query interval, matching bases and block length on the last op.
// Depends on cag_pkg.
`default_nettype none

// One CIGAR op is taken per cycle while the output does not stall. Each op
// passes an input register and the accumulate stage; the last op of a record
// passes on to a snapshot register and then the output register. Non-last ops
// produce no output word. The input side keeps accepting while a result waits
// on the output, until the input and snapshot registers are both full.
module cigar_alignment_geometry_core
  import cag_pkg::*;
#(
  parameter int OP_LEN_BITS = OP_LEN_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF,
  localparam int S_TDATA_W  = ((CODE_BITS + OP_LEN_BITS + 2 * TAG_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // op_code, op_len, edit_distance, ambiguous_bases
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // is_first, reverse_strand, has_edit_distance
  input  wire logic [2:0]           s_axis_tuser,
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // query_length, query_start, query_end, matching_bases, block_length
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // overflow
  output logic                      m_axis_tuser
);

  localparam int LEN_LSB = CODE_BITS;
  localparam int NM_LSB  = CODE_BITS + OP_LEN_BITS;
  localparam int AMB_LSB = NM_LSB + TAG_BITS;

  logic in_en, fin_en, out_en, move;

  // input register
  logic                   in_valid;
  logic [CODE_BITS-1:0]   in_code;
  logic [OP_LEN_BITS-1:0] in_len;
  logic                   in_first, in_last, in_rev, in_has_nm;
  logic [TAG_BITS-1:0]    in_nm, in_amb;

  // record state
  logic [ACC_BITS-1:0]    match_sum, mismatch_x_sum, insert_sum, delete_sum, clip_sum;
  logic [OP_LEN_BITS-1:0] lead_clip, trail_clip;
  logic                   saw_plain_match, saw_extended, overflow_seen;

  logic [ACC_BITS-1:0]    match_next, mismatch_next, insert_next, delete_next, clip_next;
  logic [OP_LEN_BITS-1:0] lead_next, trail_next;
  logic                   plain_next, ext_next, ovf_next;

  // snapshot of a finished record
  logic                   fin_valid;
  logic [ACC_BITS-1:0]    fin_match, fin_mismatch, fin_insert, fin_delete, fin_clip;
  logic [OP_LEN_BITS-1:0] fin_lead, fin_trail;
  logic                   fin_plain, fin_ext, fin_ovf, fin_rev, fin_has_nm;
  logic [TAG_BITS-1:0]    fin_nm, fin_amb;

  assign out_en        = !m_axis_tvalid || m_axis_tready;
  assign fin_en        = !fin_valid || out_en;
  assign in_en         = !in_valid || fin_en;
  assign move          = in_valid && fin_en;
  assign s_axis_tready = in_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_en) begin
      in_valid <= s_axis_tvalid;
    end
    if (in_en && s_axis_tvalid) begin
      in_code   <= s_axis_tdata[CODE_BITS-1:0];
      in_len    <= s_axis_tdata[LEN_LSB +: OP_LEN_BITS];
      in_nm     <= s_axis_tdata[NM_LSB +: TAG_BITS];
      in_amb    <= s_axis_tdata[AMB_LSB +: TAG_BITS];
      in_first  <= s_axis_tuser[0];
      in_rev    <= s_axis_tuser[1];
      in_has_nm <= s_axis_tuser[2];
      in_last   <= s_axis_tlast;
    end
  end

  // accumulate one op
  always_comb begin
    logic [ACC_BITS-1:0] len_acc;
    logic [ACC_BITS:0]   m_add, x_add, i_add, d_add, c_add;
    len_acc = ACC_BITS'(in_len);
    if (in_first) begin
      match_next    = '0;
      mismatch_next = '0;
      insert_next   = '0;
      delete_next   = '0;
      clip_next     = '0;
      lead_next     = '0;
      trail_next    = '0;
      plain_next    = 1'b0;
      ext_next      = 1'b0;
      ovf_next      = 1'b0;
    end else begin
      match_next    = match_sum;
      mismatch_next = mismatch_x_sum;
      insert_next   = insert_sum;
      delete_next   = delete_sum;
      clip_next     = clip_sum;
      lead_next     = lead_clip;
      trail_next    = trail_clip;
      plain_next    = saw_plain_match;
      ext_next      = saw_extended;
      ovf_next      = overflow_seen;
    end
    m_add = {1'b0, match_next} + {1'b0, len_acc};
    x_add = {1'b0, mismatch_next} + {1'b0, len_acc};
    i_add = {1'b0, insert_next} + {1'b0, len_acc};
    d_add = {1'b0, delete_next} + {1'b0, len_acc};
    c_add = {1'b0, clip_next} + {1'b0, len_acc};
    unique case (in_code)
      OP_M: begin
        match_next = m_add[ACC_BITS-1:0];
        ovf_next   = ovf_next | m_add[ACC_BITS];
        plain_next = 1'b1;
      end
      OP_EQ: begin
        match_next = m_add[ACC_BITS-1:0];
        ovf_next   = ovf_next | m_add[ACC_BITS];
        ext_next   = 1'b1;
      end
      OP_X: begin
        match_next    = m_add[ACC_BITS-1:0];
        mismatch_next = x_add[ACC_BITS-1:0];
        ovf_next      = ovf_next | m_add[ACC_BITS] | x_add[ACC_BITS];
        ext_next      = 1'b1;
      end
      OP_I: begin
        insert_next = i_add[ACC_BITS-1:0];
        ovf_next    = ovf_next | i_add[ACC_BITS];
      end
      OP_D: begin
        delete_next = d_add[ACC_BITS-1:0];
        ovf_next    = ovf_next | d_add[ACC_BITS];
      end
      OP_S, OP_H: begin
        clip_next = c_add[ACC_BITS-1:0];
        ovf_next  = ovf_next | c_add[ACC_BITS];
        if (in_first) begin
          lead_next = in_len;
        end else if (in_last) begin
          trail_next = in_len;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_sum       <= '0;
      mismatch_x_sum  <= '0;
      insert_sum      <= '0;
      delete_sum      <= '0;
      clip_sum        <= '0;
      lead_clip       <= '0;
      trail_clip      <= '0;
      saw_plain_match <= 1'b0;
      saw_extended    <= 1'b0;
      overflow_seen   <= 1'b0;
      fin_valid       <= 1'b0;
    end else begin
      if (move) begin
        if (in_last) begin
          match_sum       <= '0;
          mismatch_x_sum  <= '0;
          insert_sum      <= '0;
          delete_sum      <= '0;
          clip_sum        <= '0;
          lead_clip       <= '0;
          trail_clip      <= '0;
          saw_plain_match <= 1'b0;
          saw_extended    <= 1'b0;
          overflow_seen   <= 1'b0;
        end else begin
          match_sum       <= match_next;
          mismatch_x_sum  <= mismatch_next;
          insert_sum      <= insert_next;
          delete_sum      <= delete_next;
          clip_sum        <= clip_next;
          lead_clip       <= lead_next;
          trail_clip      <= trail_next;
          saw_plain_match <= plain_next;
          saw_extended    <= ext_next;
          overflow_seen   <= ovf_next;
        end
      end
      if (fin_en) begin
        fin_valid <= in_valid && in_last;
      end
    end
    if (move && in_last) begin
      fin_match    <= match_next;
      fin_mismatch <= mismatch_next;
      fin_insert   <= insert_next;
      fin_delete   <= delete_next;
      fin_clip     <= clip_next;
      fin_lead     <= lead_next;
      fin_trail    <= trail_next;
      fin_plain    <= plain_next;
      fin_ext      <= ext_next;
      fin_ovf      <= ovf_next;
      fin_rev      <= in_rev;
      fin_has_nm   <= in_has_nm;
      fin_nm       <= in_nm;
      fin_amb      <= in_amb;
    end
  end

  // record geometry
  logic [ACC_BITS:0]   mi_add, qlen_add, gap_add, blk_add;
  logic [ACC_BITS-1:0] qlen, gaps, bsum, qstart, other_clip, qend;
  logic [ACC_BITS-1:0] nm_acc, amb_acc, mism, mlen, blen;
  logic                res_ovf;

  always_comb begin
    mi_add   = {1'b0, fin_match} + {1'b0, fin_insert};
    qlen_add = {1'b0, mi_add[ACC_BITS-1:0]} + {1'b0, fin_clip};
    gap_add  = {1'b0, fin_insert} + {1'b0, fin_delete};
    qlen     = qlen_add[ACC_BITS-1:0];
    gaps     = gap_add[ACC_BITS-1:0];
    blk_add  = {1'b0, fin_match} + {1'b0, gaps};
    bsum     = blk_add[ACC_BITS-1:0];
    res_ovf  = fin_ovf | mi_add[ACC_BITS] | qlen_add[ACC_BITS] | gap_add[ACC_BITS]
               | blk_add[ACC_BITS];

    qstart     = fin_rev ? ACC_BITS'(fin_trail) : ACC_BITS'(fin_lead);
    other_clip = fin_rev ? ACC_BITS'(fin_lead) : ACC_BITS'(fin_trail);
    qend       = (qlen > other_clip) ? qlen - other_clip : '0;

    nm_acc = ACC_BITS'(fin_nm[TAG_BITS-2:0]);
    if (fin_ext && !fin_plain) begin
      mism = fin_mismatch;
    end else if (fin_has_nm && !fin_nm[TAG_BITS-1] && fin_nm != '0) begin
      mism = (nm_acc > gaps) ? nm_acc - gaps : '0;
    end else begin
      mism = '0;
    end
    mlen = (fin_match > mism) ? fin_match - mism : '0;

    amb_acc = fin_amb[TAG_BITS-1] ? '0 : ACC_BITS'(fin_amb[TAG_BITS-2:0]);
    blen    = (bsum > amb_acc) ? bsum - amb_acc : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= fin_valid;
    end
    if (out_en && fin_valid) begin
      m_axis_tdata <= {OUT_BITS'(blen), OUT_BITS'(mlen), OUT_BITS'(qend),
                       OUT_BITS'(qstart), OUT_BITS'(qlen)};
      m_axis_tuser <= res_ovf;
    end
  end

`ifndef ASSERT_OFF
  a_out_from_record: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(fin_valid))
    else $error("output word without a finished record");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    move && in_last |=> match_sum == '0 && clip_sum == '0 && !overflow_seen
      && !saw_plain_match && !saw_extended)
    else $error("record state not cleared after last op");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !out_en |=> fin_valid && $stable(fin_match) && $stable(fin_clip))
    else $error("finished record lost while output stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for cigar_alignment_geometry_core: streams CIGAR op
// words and checks each per-record geometry word against a local predictor.
// Depends on cag_pkg and the core RTL.
`default_nettype none

module tb;
  import cag_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W    = OP_LEN_BITS_DEF;
  localparam int ACC_W    = ACC_BITS_DEF;
  localparam int S_W      = ((CODE_BITS + LEN_W + 2 * TAG_BITS + 7) / 8) * 8;
  localparam int IDLE_MAX = 1000;

  localparam logic [63:0]          ACC_MASK      = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ACC_W);
  localparam logic [LEN_W-1:0]     LEN_MAX       = '1;
  localparam logic signed [31:0]   TAG_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]   TAG_MIN       = 32'sh8000_0000;
  localparam logic [CODE_BITS-1:0] OP_UNUSED_LO  = OP_X + 4'd1;
  localparam logic [CODE_BITS-1:0] OP_UNUSED_HI  = '1;

  typedef struct {
    logic [CODE_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
    bit                   first;
    bit                   last;
    bit                   rev;
    bit                   has_nm;
    logic signed [31:0]   nm;
    logic signed [31:0]   amb;
  } op_item_t;

  typedef struct {
    logic [OUT_BITS-1:0] qlen;
    logic [OUT_BITS-1:0] qstart;
    logic [OUT_BITS-1:0] qend;
    logic [OUT_BITS-1:0] mbases;
    logic [OUT_BITS-1:0] blen;
    bit                  ovf;
  } geom_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_W-1:0]       s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  cigar_alignment_geometry_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [63:0]      acc_match, acc_mismatch, acc_ins, acc_del, acc_clip;
  logic [LEN_W-1:0] clip_lead, clip_trail;
  bit               seen_m, seen_ext, seen_ovf;

  geom_t geometry_q[$];
  int    err_count   = 0;
  int    ops_sent    = 0;
  int    tx_gap_max  = 4;
  int    rx_stall_max = 4;
  int    rx_wait     = 0;
  int    idle_cycles = 0;

  function automatic void clear_geometry();
    acc_match = 0; acc_mismatch = 0; acc_ins = 0; acc_del = 0; acc_clip = 0;
    clip_lead = 0; clip_trail = 0;
    seen_m = 0; seen_ext = 0; seen_ovf = 0;
  endfunction

  function automatic logic [63:0] wrap_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (s > ACC_MASK) seen_ovf = 1;
    return s & ACC_MASK;
  endfunction

  function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  // advances the record state by one op; returns 1 with the geometry on a last op
  function automatic bit cigar_step(input op_item_t it, output geom_t g);
    logic [63:0] qlen, qstart, qend, gaps, mism, bsum, ambu, mlen, blen;
    if (it.first) clear_geometry();
    case (it.code)
      OP_M: begin
        acc_match = wrap_add(acc_match, 64'(it.len));
        seen_m = 1;
      end
      OP_EQ: begin
        acc_match = wrap_add(acc_match, 64'(it.len));
        seen_ext = 1;
      end
      OP_X: begin
        acc_match = wrap_add(acc_match, 64'(it.len));
        acc_mismatch = wrap_add(acc_mismatch, 64'(it.len));
        seen_ext = 1;
      end
      OP_I: acc_ins = wrap_add(acc_ins, 64'(it.len));
      OP_D: acc_del = wrap_add(acc_del, 64'(it.len));
      OP_S, OP_H: begin
        acc_clip = wrap_add(acc_clip, 64'(it.len));
        if (it.first) clip_lead = it.len;
        else if (it.last) clip_trail = it.len;
      end
      default: ;
    endcase
    if (!it.last) return 0;
    qlen = wrap_add(wrap_add(acc_match, acc_ins), acc_clip);
    if (it.rev) begin
      qstart = 64'(clip_trail);
      qend   = floor_sub(qlen, 64'(clip_lead));
    end else begin
      qstart = 64'(clip_lead);
      qend   = floor_sub(qlen, 64'(clip_trail));
    end
    gaps = wrap_add(acc_ins, acc_del);
    mism = 0;
    if (seen_ext && !seen_m) mism = acc_mismatch;
    else if (it.has_nm && it.nm > 0) mism = floor_sub({32'd0, it.nm}, gaps);
    bsum = wrap_add(acc_match, gaps);
    ambu = (it.amb > 0) ? {32'd0, it.amb} : 64'd0;
    mlen = floor_sub(acc_match, mism);
    blen = floor_sub(bsum, ambu);
    g.qlen   = qlen[OUT_BITS-1:0];
    g.qstart = qstart[OUT_BITS-1:0];
    g.qend   = qend[OUT_BITS-1:0];
    g.mbases = mlen[OUT_BITS-1:0];
    g.blen   = blen[OUT_BITS-1:0];
    g.ovf    = seen_ovf;
    clear_geometry();
    return 1;
  endfunction

  function automatic op_item_t op(input logic [CODE_BITS-1:0] code, input logic [LEN_W-1:0] len,
                                  input bit first = 0, input bit last = 0, input bit rev = 0,
                                  input bit has_nm = 0, input logic signed [31:0] nm = 0,
                                  input logic signed [31:0] amb = 0);
    op_item_t it;
    it.code = code; it.len = len; it.first = first; it.last = last;
    it.rev = rev; it.has_nm = has_nm; it.nm = nm; it.amb = amb;
    return it;
  endfunction

  task automatic send_op(input op_item_t it);
    int    gap;
    geom_t g;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.amb, it.nm, it.len, it.code};
    s_axis_tuser  <= {it.has_nm, it.rev, it.first};
    s_axis_tlast  <= it.last;
    do @(posedge clk); while (!s_axis_tready);
    if (cigar_step(it, g)) geometry_q = {geometry_q, g};
    ops_sent++;
  endtask

  task automatic check_field(input string name, input logic [OUT_BITS-1:0] exp_v,
                             input logic [OUT_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // result checker and output-side stalls
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (geometry_q.size() == 0) begin
          $error("result word with no record pending");
          err_count++;
        end else begin
          geom_t g;
          g = geometry_q.pop_front();
          check_field("query_length",   g.qlen,   m_axis_tdata[0*OUT_BITS +: OUT_BITS]);
          check_field("query_start",    g.qstart, m_axis_tdata[1*OUT_BITS +: OUT_BITS]);
          check_field("query_end",      g.qend,   m_axis_tdata[2*OUT_BITS +: OUT_BITS]);
          check_field("matching_bases", g.mbases, m_axis_tdata[3*OUT_BITS +: OUT_BITS]);
          check_field("block_length",   g.blen,   m_axis_tdata[4*OUT_BITS +: OUT_BITS]);
          check_field("overflow",       OUT_BITS'(g.ovf), OUT_BITS'(m_axis_tuser));
        end
      end
      if (m_axis_tready) begin
        if (m_axis_tvalid) begin
          stall = $urandom_range(0, rx_stall_max);
          rx_wait <= stall;
          if (stall != 0) m_axis_tready <= 1'b0;
        end
      end else if (rx_wait <= 1) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    // empty CIGAR
    send_op(op(OP_P, 0, 1, 1));
    // soft clips both ends, forward strand, NM and nn present
    send_op(op(OP_S, 5, 1, 0));
    send_op(op(OP_M, 100));
    send_op(op(OP_I, 3));
    send_op(op(OP_D, 7));
    send_op(op(OP_N, 50));
    send_op(op(OP_S, 9, 0, 1, 0, 1, 20, 4));
    // hard clips, reverse strand, negative tags
    send_op(op(OP_H, 11, 1, 0));
    send_op(op(OP_M, LEN_MAX));
    send_op(op(OP_H, 2, 0, 1, 1, 1, -5, -3));
    // pure extended CIGAR: X count wins over NM
    send_op(op(OP_EQ, 50, 1, 0));
    send_op(op(OP_X, 7));
    send_op(op(OP_EQ, 10, 0, 1, 0, 1, TAG_MAX, 0));
    // mixed M and X, huge NM and nn floor to zero
    send_op(op(OP_M, 30, 1, 0));
    send_op(op(OP_X, 4));
    send_op(op(OP_I, 2, 0, 1, 0, 1, TAG_MAX, TAG_MAX));
    // record with no first mark after an emit
    send_op(op(OP_M, 8));
    send_op(op(OP_D, 1, 0, 1, 0, 1, TAG_MIN, TAG_MIN));
    // several clips at each end
    send_op(op(OP_S, 3, 1, 0));
    send_op(op(OP_H, 4));
    send_op(op(OP_M, 20));
    send_op(op(OP_H, 6));
    send_op(op(OP_S, 1, 0, 1, 1));
    // lone clip marked first and last
    send_op(op(OP_S, 12, 1, 1, 1));
    // unused codes, restart mid-record
    send_op(op(OP_M, 10, 1, 0));
    send_op(op(OP_UNUSED_HI, LEN_MAX));
    send_op(op(OP_M, 20, 1, 0));
    send_op(op(OP_UNUSED_LO, 0, 0, 1, 0, 1, 1, 1));
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return LEN_MAX;
      2, 3:    return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, 500));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_tag();
    case ($urandom_range(0, 9))
      0:       return TAG_MIN;
      1:       return TAG_MAX;
      2, 3:    return $urandom;
      4:       return -$urandom_range(1, 50);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic op_item_t rand_op(input logic [CODE_BITS-1:0] code);
    return op(code, rand_len(), 0, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              rand_tag(), rand_tag());
  endfunction

  task automatic send_record();
    op_item_t             rec[$];
    int                   style, nbody;
    logic [CODE_BITS-1:0] code;
    style = $urandom_range(0, 2);
    nbody = $urandom_range(0, 6);
    if ($urandom_range(0, 2) == 0) rec = {rec, rand_op($urandom_range(0, 1) ? OP_S : OP_H)};
    repeat (nbody) begin
      case (style)
        0: case ($urandom_range(0, 5))
             0, 1, 2: code = OP_M;
             3:       code = OP_I;
             4:       code = OP_D;
             default: code = OP_N;
           endcase
        1: case ($urandom_range(0, 4))
             0, 1:    code = OP_EQ;
             2:       code = OP_X;
             3:       code = OP_I;
             default: code = OP_D;
           endcase
        default: code = CODE_BITS'($urandom_range(OP_M, OP_X));
      endcase
      if ($urandom_range(0, 9) == 0) code = CODE_BITS'($urandom_range(OP_P, OP_UNUSED_HI));
      rec = {rec, rand_op(code)};
    end
    if ($urandom_range(0, 2) == 0) rec = {rec, rand_op($urandom_range(0, 1) ? OP_S : OP_H)};
    if (rec.size() == 0) rec = {rec, op(OP_P, 0, 0, 0, 1'($urandom_range(0, 1)))};
    rec[0].first = 1;
    rec[rec.size()-1].last = 1;
    foreach (rec[i]) send_op(rec[i]);
  endtask

  task automatic test_random();
    int start, nrec;
    op_item_t it;
    start = ops_sent;
    nrec  = 0;
    while (ops_sent - start < 500) begin
      if (nrec % 10 == 0) begin
        tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 4;
        rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      end
      if ($urandom_range(0, 6) == 0) begin
        it = rand_op(CODE_BITS'($urandom_range(OP_M, OP_UNUSED_HI)));
        it.first = 1'($urandom_range(0, 1));
        it.last  = 1'($urandom_range(0, 1));
        send_op(it);
      end else begin
        send_record();
      end
      nrec++;
    end
    tx_gap_max   = 4;
    rx_stall_max = 4;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (geometry_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
